FILE: rtl/core/rotation_bilinear_source_mapper_defines.svh
// Assertion macros used by the checker file of the rotation source mapper.
`ifndef ROTATION_BILINEAR_SOURCE_MAPPER_DEFINES_SVH
`define ROTATION_BILINEAR_SOURCE_MAPPER_DEFINES_SVH

// Same-cycle implication, muted while reset is high.
`define RBSM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted while reset is high.
`define RBSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define RBSM_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rbsm_pkg.sv
// Types, constants and helper functions of the rotation source mapper.
package rbsm_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int MAX_DIM     = 4096;
   localparam int XY_W        = 32;
   localparam int FLOOR_W     = XY_W - FRAC_BITS;
   localparam int PROD_W      = 30;
   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [14:0] COORD_MIN  = -15'sd16384;
   localparam logic signed [14:0] COORD_MAX  = 15'sd16383;
   localparam logic [25:0]        OFFSET_MAX = 26'h3FFFFFF;

   typedef enum logic [2:0] {
      CSR_COS_ANGLE,
      CSR_SIN_ANGLE,
      CSR_SRC_WIDTH,
      CSR_SRC_HEIGHT,
      CSR_OUT_CENTER_X,
      CSR_OUT_CENTER_Y,
      CSR_SRC_ROW_BYTES,
      CSR_BYTES_PER_PIXEL
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] cos_angle;
      logic signed [15:0] sin_angle;
      logic [12:0]        src_width;
      logic [12:0]        src_height;
      logic [12:0]        out_center_x;
      logic [12:0]        out_center_y;
      logic [14:0]        src_row_bytes;
      logic [2:0]         bytes_per_pixel;
   } cfg_type;

   // Classified coordinate handed from the front end to the back end.
   typedef struct packed {
      logic                       in_bounds;
      logic signed [FLOOR_W-1:0]  x_floor;
      logic signed [FLOOR_W-1:0]  y_floor;
      logic [FRAC_BITS-1:0]       frac_x;
      logic [FRAC_BITS-1:0]       frac_y;
   } mid_type;

   function automatic logic [12:0] clamp_dim(input logic [12:0] v);
      clamp_dim = (v > 13'(MAX_DIM)) ? 13'(MAX_DIM) : v;
   endfunction

endpackage

FILE: rtl/core/rbsm_channels.sv
// Valid/ready channel interfaces for coordinate requests and mapped results.
interface rbsm_req_if;
   logic        valid;
   logic        ready;
   logic [12:0] out_x;
   logic [12:0] out_y;

   modport source(output valid, output out_x, output out_y, input ready);
   modport sink(input valid, input out_x, input out_y, output ready);
endinterface

interface rbsm_rsp_if;
   logic               valid;
   logic               ready;
   logic               inside_res;
   logic signed [14:0] src_x0;
   logic signed [14:0] src_y0;
   logic [13:0]        frac_x;
   logic [13:0]        frac_y;
   logic [14:0]        weight_00;
   logic [14:0]        weight_01;
   logic [14:0]        weight_10;
   logic [14:0]        weight_11;
   logic [25:0]        byte_offset;

   modport source(output valid, output inside_res, output src_x0, output src_y0,
                  output frac_x, output frac_y, output weight_00, output weight_01,
                  output weight_10, output weight_11, output byte_offset, input ready);
   modport sink(input valid, input inside_res, input src_x0, input src_y0,
                input frac_x, input frac_y, input weight_00, input weight_01,
                input weight_10, input weight_11, input byte_offset, output ready);
endinterface

FILE: rtl/core/rotation_bilinear_source_mapper.sv
// Top level of the rotation source mapper with bilinear weights.
//
// The block takes one output pixel coordinate per item on req_chan (out_x, out_y)
// and returns one item on rsp_chan: the inverse-rotated source position split
// into floor and Q0.14 fraction, the four bilinear weights, an inside flag and
// the byte offset of the top-left source neighbor (zero when outside).
// Rotation, source size, output center, row pitch and pixel size come from the
// csr_ write port, one register per write, and are to be changed only while
// idle; the user must ensure this, as the block does not enforce it. When a
// request is accepted its rotation products are registered, then the sums,
// then the item enters the two-entry queue, and the back end then registers
// the weight and offset products and finally the offset sum into the output
// register. Throughput is one item per clock; each stage holds one item and
// advances whenever the next stage has room.
// When the receiver stalls, the result stays on rsp_chan unchanged, the back
// end fills, the queue absorbs two more items and the front end then holds
// req_chan.ready low. Synchronous reset empties every stage and the queue and
// returns the configuration registers to their documented reset values.
module rotation_bilinear_source_mapper (
   input  logic        clock,
   input  logic        reset,
   rbsm_req_if.sink    req_chan,
   rbsm_rsp_if.source  rsp_chan,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   rbsm_pkg::cfg_type cfg_ff;
   rbsm_pkg::cfg_type cfg_in;
   rbsm_pkg::mid_type front_item;
   rbsm_pkg::mid_type back_item;
   logic              front_valid;
   logic              front_ready;
   logic              back_valid;
   logic              back_ready;

   // Register file: a write lands in the field picked by the index.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (rbsm_pkg::csr_index_type'(csr_index))
            rbsm_pkg::CSR_COS_ANGLE:       cfg_in.cos_angle       = $signed(csr_write_data);
            rbsm_pkg::CSR_SIN_ANGLE:       cfg_in.sin_angle       = $signed(csr_write_data);
            rbsm_pkg::CSR_SRC_WIDTH:       cfg_in.src_width       = csr_write_data[12:0];
            rbsm_pkg::CSR_SRC_HEIGHT:      cfg_in.src_height      = csr_write_data[12:0];
            rbsm_pkg::CSR_OUT_CENTER_X:    cfg_in.out_center_x    = csr_write_data[12:0];
            rbsm_pkg::CSR_OUT_CENTER_Y:    cfg_in.out_center_y    = csr_write_data[12:0];
            rbsm_pkg::CSR_SRC_ROW_BYTES:   cfg_in.src_row_bytes   = csr_write_data[14:0];
            rbsm_pkg::CSR_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_write_data[2:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_angle       <= 16'sd16384;
         cfg_ff.sin_angle       <= 16'sd0;
         cfg_ff.src_width       <= 13'd1;
         cfg_ff.src_height      <= 13'd1;
         cfg_ff.out_center_x    <= 13'd0;
         cfg_ff.out_center_y    <= 13'd0;
         cfg_ff.src_row_bytes   <= 15'd4;
         cfg_ff.bytes_per_pixel <= 3'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_chan  (req_chan),
      .mid_valid (front_valid),
      .mid_ready (front_ready),
      .mid_item  (front_item)
   );

   rbsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   rbsm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (back_valid),
      .in_ready (back_ready),
      .in_item  (back_item),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: rtl/core/rbsm_front.sv
// Front end: accepts coordinates, rotates them and classifies the mapped point.
module rbsm_front (
   input  logic              clock,
   input  logic              reset,
   input  rbsm_pkg::cfg_type cfg,
   rbsm_req_if.sink          req_chan,
   output logic              mid_valid,
   input  logic              mid_ready,
   output rbsm_pkg::mid_type mid_item
);

   localparam int PW = rbsm_pkg::PROD_W;
   localparam int XW = rbsm_pkg::XY_W;

   logic signed [13:0]   dx;
   logic signed [13:0]   dy;
   logic                 a_ready;
   logic                 b_ready;

   logic                 a_valid_ff;
   logic signed [PW-1:0] prod_xc_ff, prod_xc_in;
   logic signed [PW-1:0] prod_ys_ff, prod_ys_in;
   logic signed [PW-1:0] prod_xs_ff, prod_xs_in;
   logic signed [PW-1:0] prod_yc_ff, prod_yc_in;

   logic                 b_valid_ff;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [XW-1:0] y_ff, y_in;

   logic [12:0]          w_clamp;
   logic [12:0]          h_clamp;
   logic signed [XW-1:0] x_bias;
   logic signed [XW-1:0] y_bias;
   logic [XW-2:0]        x_limit;
   logic [XW-2:0]        y_limit;

   assign b_ready        = !b_valid_ff || mid_ready;
   assign a_ready        = !a_valid_ff || b_ready;
   assign req_chan.ready = a_ready;

   // Stage A: offsets from the output center and the four rotation products.
   assign dx = $signed({1'b0, req_chan.out_x}) - $signed({1'b0, cfg.out_center_x});
   assign dy = $signed({1'b0, req_chan.out_y}) - $signed({1'b0, cfg.out_center_y});
   assign prod_xc_in = dx * cfg.cos_angle;
   assign prod_ys_in = dy * cfg.sin_angle;
   assign prod_xs_in = dx * cfg.sin_angle;
   assign prod_yc_in = dy * cfg.cos_angle;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_chan.valid;
      end
      if (a_ready && req_chan.valid) begin
         prod_xc_ff <= prod_xc_in;
         prod_ys_ff <= prod_ys_in;
         prod_xs_ff <= prod_xs_in;
         prod_yc_ff <= prod_yc_in;
      end
   end

   // Stage B: source coordinates with the half source size added.
   assign w_clamp = rbsm_pkg::clamp_dim(cfg.src_width);
   assign h_clamp = rbsm_pkg::clamp_dim(cfg.src_height);
   assign x_bias  = $signed(XW'(w_clamp >> 1) << rbsm_pkg::FRAC_BITS);
   assign y_bias  = $signed(XW'(h_clamp >> 1) << rbsm_pkg::FRAC_BITS);
   assign x_in = XW'(prod_xc_ff) - XW'(prod_ys_ff) + x_bias;
   assign y_in = XW'(prod_xs_ff) + XW'(prod_yc_ff) + y_bias;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   // Split into floor and fraction and test against the source bounds.
   assign x_limit = (XW-1)'(w_clamp) << rbsm_pkg::FRAC_BITS;
   assign y_limit = (XW-1)'(h_clamp) << rbsm_pkg::FRAC_BITS;

   assign mid_valid          = b_valid_ff;
   assign mid_item.in_bounds = !x_ff[XW-1] && (x_ff[XW-2:0] < x_limit) &&
                               !y_ff[XW-1] && (y_ff[XW-2:0] < y_limit);
   assign mid_item.x_floor   = x_ff[XW-1:rbsm_pkg::FRAC_BITS];
   assign mid_item.y_floor   = y_ff[XW-1:rbsm_pkg::FRAC_BITS];
   assign mid_item.frac_x    = x_ff[rbsm_pkg::FRAC_BITS-1:0];
   assign mid_item.frac_y    = y_ff[rbsm_pkg::FRAC_BITS-1:0];

endmodule

FILE: rtl/core/rbsm_queue.sv
// Short FIFO that decouples the front end from the back end.
module rbsm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rbsm_pkg::mid_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output rbsm_pkg::mid_type pop_item
);

   localparam int DEPTH = rbsm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rbsm_pkg::mid_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: rtl/core/rbsm_back.sv
// Back end: bilinear weights, saturated coordinates and the neighbor byte offset.
module rbsm_back (
   input  logic              clock,
   input  logic              reset,
   input  rbsm_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  rbsm_pkg::mid_type in_item,
   rbsm_rsp_if.source        rsp_chan
);

   localparam int FB = rbsm_pkg::FRAC_BITS;
   localparam int WW = 2 * (FB + 1) - 1;

   function automatic logic signed [14:0] sat_coord(
      input logic signed [rbsm_pkg::FLOOR_W-1:0] v);
      if (v < rbsm_pkg::FLOOR_W'(rbsm_pkg::COORD_MIN)) begin
         sat_coord = rbsm_pkg::COORD_MIN;
      end else if (v > rbsm_pkg::FLOOR_W'(rbsm_pkg::COORD_MAX)) begin
         sat_coord = rbsm_pkg::COORD_MAX;
      end else begin
         sat_coord = v[14:0];
      end
   endfunction

   logic                 c_ready;
   logic                 d_ready;
   logic [FB:0]          gx;
   logic [FB:0]          gy;

   logic                 c_valid_ff;
   logic                 c_inside_ff;
   logic signed [14:0]   c_x0_ff;
   logic signed [14:0]   c_y0_ff;
   logic [FB-1:0]        c_fx_ff;
   logic [FB-1:0]        c_fy_ff;
   logic [WW-1:0]        w00_ff, w00_in;
   logic [WW-1:0]        w01_ff, w01_in;
   logic [WW-1:0]        w10_ff, w10_in;
   logic [WW-1:0]        w11_ff, w11_in;
   logic [27:0]          off_y_ff, off_y_in;
   logic [15:0]          off_x_ff, off_x_in;

   logic                 d_valid_ff;
   logic                 inside_ff;
   logic signed [14:0]   x0_ff;
   logic signed [14:0]   y0_ff;
   logic [13:0]          fx_ff;
   logic [13:0]          fy_ff;
   logic [14:0]          weight_00_ff;
   logic [14:0]          weight_01_ff;
   logic [14:0]          weight_10_ff;
   logic [14:0]          weight_11_ff;
   logic [25:0]          offset_ff, offset_in;
   logic [28:0]          offset_sum;

   assign d_ready  = !d_valid_ff || rsp_chan.ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   // Stage C: complementary fractions, weight products and offset products.
   assign gx = (FB+1)'(1 << FB) - {1'b0, in_item.frac_x};
   assign gy = (FB+1)'(1 << FB) - {1'b0, in_item.frac_y};
   assign w00_in = WW'(gx * gy);
   assign w01_in = WW'(gx * {1'b0, in_item.frac_y});
   assign w10_in = WW'({1'b0, in_item.frac_x} * gy);
   assign w11_in = WW'(in_item.frac_x * in_item.frac_y);
   // Inside the source both floors lie in 0..MAX_DIM-1, so 13 bits suffice.
   assign off_y_in = 28'(in_item.y_floor[12:0]) * 28'(cfg.src_row_bytes);
   assign off_x_in = 16'(in_item.x_floor[12:0]) * 16'(cfg.bytes_per_pixel);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= in_valid;
      end
      if (c_ready && in_valid) begin
         c_inside_ff <= in_item.in_bounds;
         c_x0_ff     <= sat_coord(in_item.x_floor);
         c_y0_ff     <= sat_coord(in_item.y_floor);
         c_fx_ff     <= in_item.frac_x;
         c_fy_ff     <= in_item.frac_y;
         w00_ff      <= w00_in;
         w01_ff      <= w01_in;
         w10_ff      <= w10_in;
         w11_ff      <= w11_in;
         off_y_ff    <= off_y_in;
         off_x_ff    <= off_x_in;
      end
   end

   // Stage D: offset sum with saturation, zero outside the source, then the output register.
   assign offset_sum = 29'(off_y_ff) + 29'(off_x_ff);
   always_comb begin
      if (!c_inside_ff) begin
         offset_in = '0;
      end else if (offset_sum > 29'(rbsm_pkg::OFFSET_MAX)) begin
         offset_in = rbsm_pkg::OFFSET_MAX;
      end else begin
         offset_in = offset_sum[25:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_ready) begin
         d_valid_ff <= c_valid_ff;
      end
      if (d_ready && c_valid_ff) begin
         inside_ff    <= c_inside_ff;
         x0_ff        <= c_x0_ff;
         y0_ff        <= c_y0_ff;
         fx_ff        <= 14'(c_fx_ff);
         fy_ff        <= 14'(c_fy_ff);
         weight_00_ff <= 15'(w00_ff[WW-1:FB]);
         weight_01_ff <= 15'(w01_ff[WW-1:FB]);
         weight_10_ff <= 15'(w10_ff[WW-1:FB]);
         weight_11_ff <= 15'(w11_ff[WW-1:FB]);
         offset_ff    <= offset_in;
      end
   end

   assign rsp_chan.valid       = d_valid_ff;
   assign rsp_chan.inside_res  = inside_ff;
   assign rsp_chan.src_x0      = x0_ff;
   assign rsp_chan.src_y0      = y0_ff;
   assign rsp_chan.frac_x      = fx_ff;
   assign rsp_chan.frac_y      = fy_ff;
   assign rsp_chan.weight_00   = weight_00_ff;
   assign rsp_chan.weight_01   = weight_01_ff;
   assign rsp_chan.weight_10   = weight_10_ff;
   assign rsp_chan.weight_11   = weight_11_ff;
   assign rsp_chan.byte_offset = offset_ff;

endmodule

FILE: rtl/core/rbsm_checker.sv
// Port-level checks of the rotation source mapper and their bind to the top level.
`include "rotation_bilinear_source_mapper_defines.svh"

module rbsm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               inside_res,
   input logic signed [14:0] src_x0,
   input logic signed [14:0] src_y0,
   input logic [13:0]        frac_x,
   input logic [14:0]        weight_00,
   input logic [14:0]        weight_10,
   input logic [14:0]        weight_11,
   input logic [25:0]        byte_offset
);

   `RBSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(inside_res) && $stable(src_x0) && $stable(src_y0) && $stable(weight_00) && $stable(byte_offset), "stalled result changed")

   `RBSM_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid, "result valid right after reset")

   `RBSM_ASSERT_SAME(a_inside_coords, clock, reset, rsp_valid && inside_res, !src_x0[14] && !src_y0[14], "inside point with negative floor")

   `RBSM_ASSERT_SAME(a_outside_offset, clock, reset, rsp_valid && !inside_res, byte_offset == 26'd0, "outside point with nonzero offset")

   `RBSM_ASSERT_SAME(a_zero_frac_weights, clock, reset, rsp_valid && (frac_x == 14'd0), (weight_10 == 15'd0) && (weight_11 == 15'd0), "right-hand weights nonzero at zero column fraction")

endmodule

bind rotation_bilinear_source_mapper rbsm_checker u_rbsm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .inside_res  (rsp_chan.inside_res),
   .src_x0      (rsp_chan.src_x0),
   .src_y0      (rsp_chan.src_y0),
   .frac_x      (rsp_chan.frac_x),
   .weight_00   (rsp_chan.weight_00),
   .weight_10   (rsp_chan.weight_10),
   .weight_11   (rsp_chan.weight_11),
   .byte_offset (rsp_chan.byte_offset)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the rotation source mapper with bilinear weights.
module tb;

   // Upper bound on the whole run, in clock cycles.
   localparam int CYCLE_LIMIT = 500000;

   // One mapped source position, as the block should return it.
   typedef struct {
      logic               in_source;
      logic signed [14:0] src_x0;
      logic signed [14:0] src_y0;
      logic [13:0]        frac_x;
      logic [13:0]        frac_y;
      logic [14:0]        weight_00;
      logic [14:0]        weight_01;
      logic [14:0]        weight_10;
      logic [14:0]        weight_11;
      logic [25:0]        byte_offset;
   } source_map_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_write_data;

   rbsm_req_if req_if();
   rbsm_rsp_if rsp_if();

   rotation_bilinear_source_mapper dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Our own copy of the register file, updated as each register is written.
   rbsm_pkg::cfg_type mapper_cfg;
   // Mapped positions still owed by the block, oldest first.
   source_map_type    pending_maps[$];
   int                map_errors = 0;
   int                cycles_run = 0;
   // Percentage that steers how often both sides idle; zero means no idling.
   int                idle_pct = 0;
   // A nonzero value asks the receiver to hold ready low for a stretch it sets.
   int                hold_request = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Clamp a floor coordinate to the signed 15-bit range of the result field.
   function automatic logic signed [14:0] clip_coord(input longint v);
      if (v < rbsm_pkg::COORD_MIN) return rbsm_pkg::COORD_MIN;
      if (v > rbsm_pkg::COORD_MAX) return rbsm_pkg::COORD_MAX;
      return 15'(v);
   endfunction

   // Inverse rotation of one output pixel into the source, with the current
   // register settings. All arithmetic is exact in 64 bits: the sums stay far
   // below that range even with every register at its widest value.
   function automatic source_map_type map_to_source(input logic [12:0] ox,
                                                    input logic [12:0] oy);
      longint         one_q, dx, dy, cos_q, sin_q, cw, ch, mx, my;
      longint         fx, fy, x0, y0, offs;
      bit             in_src;
      source_map_type m;
      one_q = longint'(1) << rbsm_pkg::FRAC_BITS;
      dx    = longint'(ox) - longint'(mapper_cfg.out_center_x);
      dy    = longint'(oy) - longint'(mapper_cfg.out_center_y);
      cos_q = longint'($signed(mapper_cfg.cos_angle));
      sin_q = longint'($signed(mapper_cfg.sin_angle));
      // Source sizes beyond the supported maximum are taken as the maximum.
      cw = longint'(mapper_cfg.src_width);
      ch = longint'(mapper_cfg.src_height);
      if (cw > rbsm_pkg::MAX_DIM) cw = rbsm_pkg::MAX_DIM;
      if (ch > rbsm_pkg::MAX_DIM) ch = rbsm_pkg::MAX_DIM;
      mx = dx * cos_q - dy * sin_q + (cw >> 1) * one_q;
      my = dx * sin_q + dy * cos_q + (ch >> 1) * one_q;
      // Floor by arithmetic shift, fraction from the low bits of the exact value.
      fx = mx & (one_q - 1);
      fy = my & (one_q - 1);
      x0 = mx >>> rbsm_pkg::FRAC_BITS;
      y0 = my >>> rbsm_pkg::FRAC_BITS;
      in_src = (mx >= 0) && (mx < cw * one_q) && (my >= 0) && (my < ch * one_q);
      // The offset is only meaningful inside the source and is zero otherwise.
      offs = 0;
      if (in_src) begin
         offs = y0 * longint'(mapper_cfg.src_row_bytes)
              + x0 * longint'(mapper_cfg.bytes_per_pixel);
         if (offs > longint'(rbsm_pkg::OFFSET_MAX)) offs = longint'(rbsm_pkg::OFFSET_MAX);
      end
      m.in_source   = in_src;
      m.src_x0      = clip_coord(x0);
      m.src_y0      = clip_coord(y0);
      m.frac_x      = 14'(fx);
      m.frac_y      = 14'(fy);
      m.weight_00   = 15'(((one_q - fx) * (one_q - fy)) >>> rbsm_pkg::FRAC_BITS);
      m.weight_01   = 15'(((one_q - fx) * fy) >>> rbsm_pkg::FRAC_BITS);
      m.weight_10   = 15'((fx * (one_q - fy)) >>> rbsm_pkg::FRAC_BITS);
      m.weight_11   = 15'((fx * fy) >>> rbsm_pkg::FRAC_BITS);
      m.byte_offset = 26'(offs);
      return m;
   endfunction

   function automatic rbsm_pkg::cfg_type make_setting(input int cos_q, input int sin_q,
                                                      input int w, input int h,
                                                      input int cx, input int cy,
                                                      input int row_bytes, input int bpp);
      rbsm_pkg::cfg_type s;
      s.cos_angle       = 16'(cos_q);
      s.sin_angle       = 16'(sin_q);
      s.src_width       = 13'(w);
      s.src_height      = 13'(h);
      s.out_center_x    = 13'(cx);
      s.out_center_y    = 13'(cy);
      s.src_row_bytes   = 15'(row_bytes);
      s.bytes_per_pixel = 3'(bpp);
      return s;
   endfunction

   // Settings for the random phases: the extremes first, then alternating
   // fully random register contents and ordinary image geometries.
   function automatic rbsm_pkg::cfg_type pick_setting(input int kind);
      int w;
      int h;
      case (kind)
         0: return make_setting(-16384, -16384, 1, 1, 0, 0, 4, 1);
         1: return make_setting(16384, 16384, 4096, 4096, 4096, 4096, 16384, 4);
         2: return make_setting(-32768, 32767, 8191, 8191, 8191, 8191, 32767, 7);
         3: return make_setting(0, 0, 0, 0, 0, 0, 0, 0);
         4: return make_setting($urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom);
         default: begin
            w = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
            h = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
            return make_setting(int'($urandom_range(0, 32768)) - 16384,
                                int'($urandom_range(0, 32768)) - 16384, w, h,
                                $urandom_range(0, 4096), $urandom_range(0, 4096),
                                4 * $urandom_range(1, 4096), $urandom_range(1, 4));
         end
      endcase
   endfunction

   // A coordinate within span of a center, kept inside the 13-bit field.
   function automatic logic [12:0] near_point(input logic [12:0] c, input int span);
      int r;
      int v;
      r = $urandom_range(0, 2 * span);
      v = int'(c) + r - span;
      if (v < 0) v = 0;
      if (v > 8191) v = 8191;
      return 13'(v);
   endfunction

   // One register write; the shadow copy follows at once since the block is
   // idle whenever registers change.
   task automatic write_reg(input rbsm_pkg::csr_index_type idx, input logic [15:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      case (idx)
         rbsm_pkg::CSR_COS_ANGLE:       mapper_cfg.cos_angle       = value;
         rbsm_pkg::CSR_SIN_ANGLE:       mapper_cfg.sin_angle       = value;
         rbsm_pkg::CSR_SRC_WIDTH:       mapper_cfg.src_width       = value[12:0];
         rbsm_pkg::CSR_SRC_HEIGHT:      mapper_cfg.src_height      = value[12:0];
         rbsm_pkg::CSR_OUT_CENTER_X:    mapper_cfg.out_center_x    = value[12:0];
         rbsm_pkg::CSR_OUT_CENTER_Y:    mapper_cfg.out_center_y    = value[12:0];
         rbsm_pkg::CSR_SRC_ROW_BYTES:   mapper_cfg.src_row_bytes   = value[14:0];
         rbsm_pkg::CSR_BYTES_PER_PIXEL: mapper_cfg.bytes_per_pixel = value[2:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_setting(input rbsm_pkg::cfg_type s);
      write_reg(rbsm_pkg::CSR_COS_ANGLE, s.cos_angle);
      write_reg(rbsm_pkg::CSR_SIN_ANGLE, s.sin_angle);
      write_reg(rbsm_pkg::CSR_SRC_WIDTH, 16'(s.src_width));
      write_reg(rbsm_pkg::CSR_SRC_HEIGHT, 16'(s.src_height));
      write_reg(rbsm_pkg::CSR_OUT_CENTER_X, 16'(s.out_center_x));
      write_reg(rbsm_pkg::CSR_OUT_CENTER_Y, 16'(s.out_center_y));
      write_reg(rbsm_pkg::CSR_SRC_ROW_BYTES, 16'(s.src_row_bytes));
      write_reg(rbsm_pkg::CSR_BYTES_PER_PIXEL, 16'(s.bytes_per_pixel));
      csr_write_en <= 1'b0;
   endtask

   // Offers one coordinate item, sometimes after a gap, and records the
   // expected mapping at the edge where the block accepts it. Valid stays
   // high after acceptance so that back-to-back items need no extra edge.
   task automatic send_coord(input logic [12:0] ox, input logic [12:0] oy);
      int gap;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 3) begin
         gap = $urandom_range(1, 13);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.out_x <= ox;
      req_if.out_y <= oy;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_maps.insert(pending_maps.size(), map_to_source(ox, oy));
   endtask

   // Stop offering items and let every owed result come back, plus a further
   // wait so the pipeline is empty before any write.
   task automatic drain_mapper();
      req_if.valid <= 1'b0;
      while (pending_maps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Mostly coordinates around the output center, so that a good share lands
   // inside the source, and the rest anywhere in the 13-bit range.
   task automatic send_random_coords(input int count);
      int span;
      span = ((mapper_cfg.src_width < mapper_cfg.src_height) ?
              mapper_cfg.src_width : mapper_cfg.src_height) / 4 + 2;
      repeat (count) begin
         if ($urandom_range(0, 3) == 0)
            send_coord(13'($urandom), 13'($urandom));
         else
            send_coord(near_point(mapper_cfg.out_center_x, span),
                       near_point(mapper_cfg.out_center_y, span));
      end
   endtask

   // The block must come out of reset with the documented register values:
   // identity rotation on a one-pixel source with a three-byte pixel.
   task automatic test_reset_values();
      mapper_cfg = make_setting(16384, 0, 1, 1, 0, 0, 4, 3);
      idle_pct   = 20;
      send_coord(13'd0, 13'd0);
      send_coord(13'd1, 13'd0);
      send_coord(13'd8191, 13'd8191);
      drain_mapper();
   endtask

   task automatic test_special_cases();
      // A plain rotation of about thirty degrees: fractions and all four
      // weights are nonzero away from the pixel grid.
      load_setting(make_setting(14189, 8192, 640, 480, 320, 240, 1920, 3));
      send_coord(13'd320, 13'd240);
      send_coord(13'd0, 13'd0);
      send_coord(13'd639, 13'd479);
      send_coord(13'd100, 13'd50);
      send_coord(13'd401, 13'd333);
      drain_mapper();
      // Largest source with an odd row pitch: the byte offset saturates,
      // and a column just past the right edge falls outside.
      load_setting(make_setting(16384, 0, 4096, 4096, 0, 0, 32767, 4));
      send_coord(13'd0, 13'd0);
      send_coord(13'd2047, 13'd2047);
      send_coord(13'd2048, 13'd0);
      drain_mapper();
      // Trigonometry beyond one, oversized source clamped to the maximum,
      // zero height so nothing is inside, and a floor that saturates low.
      load_setting(make_setting(-32768, 32767, 8191, 0, 0, 0, 32767, 0));
      send_coord(13'd8191, 13'd8191);
      send_coord(13'd0, 13'd0);
      send_coord(13'd8191, 13'd0);
      drain_mapper();
      // Floor saturating high, an odd pitch and a pixel size above four.
      load_setting(make_setting(32767, -32768, 8191, 8191, 0, 0, 4097, 5));
      send_coord(13'd8191, 13'd8191);
      send_coord(13'd0, 13'd0);
      send_coord(13'd1, 13'd0);
      drain_mapper();
      // Quarter turn on a tiny source with a pixel size of zero.
      load_setting(make_setting(0, 16384, 17, 9, 4, 4, 68, 0));
      send_coord(13'd4, 13'd4);
      send_coord(13'd0, 13'd8191);
      send_coord(13'd8191, 13'd0);
      drain_mapper();
   endtask

   // Phases with a new setting each, and idling that changes from phase to
   // phase so some stretches run with no gaps at all.
   task automatic test_random_settings();
      for (int phase = 0; phase < 12; phase++) begin
         idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 20 : 50);
         load_setting(pick_setting((phase < 4) ? phase : ((phase % 2 == 0) ? 4 : 5)));
         send_random_coords(140);
         drain_mapper();
      end
   endtask

   // The receiver stops for a long stretch while coordinates keep coming, so
   // the pipeline and its queue fill and the block must hold off its input.
   task automatic test_full_backpressure();
      idle_pct = 0;
      load_setting(pick_setting(5));
      hold_request = 300;
      send_random_coords(120);
      drain_mapper();
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_steady_stream();
      idle_pct = 0;
      load_setting(pick_setting(5));
      send_random_coords(130);
      drain_mapper();
   endtask

   // Receiver side: ready drops in random bursts while idling is on, and for
   // one long counted stretch whenever a hold is requested.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_request > 0) begin
            hold_left    = hold_request - 1;
            hold_request = 0;
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 4) begin
            hold_left = $urandom_range(0, 12);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   function automatic void check_field(input string name, input logic signed [26:0] want,
                                       input logic signed [26:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         map_errors++;
      end
   endfunction

   // Every result item taken by the receiver is held against the oldest
   // expected mapping, field by field.
   always @(posedge clock) begin
      source_map_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_maps.size() == 0) begin
            $display("%0t: result item arrived with no coordinate outstanding", $time);
            map_errors++;
         end else begin
            want = pending_maps.pop_front();
            check_field("inside_res", want.in_source, rsp_if.inside_res);
            check_field("src_x0", want.src_x0, rsp_if.src_x0);
            check_field("src_y0", want.src_y0, rsp_if.src_y0);
            check_field("frac_x", want.frac_x, rsp_if.frac_x);
            check_field("frac_y", want.frac_y, rsp_if.frac_y);
            check_field("weight_00", want.weight_00, rsp_if.weight_00);
            check_field("weight_01", want.weight_01, rsp_if.weight_01);
            check_field("weight_10", want.weight_10, rsp_if.weight_10);
            check_field("weight_11", want.weight_11, rsp_if.weight_11);
            check_field("byte_offset", want.byte_offset, rsp_if.byte_offset);
         end
      end
   end

   // Watchdog for a hung handshake.
   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("rotation_bilinear_source_mapper test failed");
         $finish;
      end
   end

   initial begin
      req_if.valid   <= 1'b0;
      req_if.out_x   <= '0;
      req_if.out_y   <= '0;
      csr_write_en   <= 1'b0;
      csr_index      <= rbsm_pkg::CSR_COS_ANGLE;
      csr_write_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_special_cases();
      test_random_settings();
      test_full_backpressure();
      test_steady_stream();

      repeat (16) @(posedge clock);
      if (map_errors == 0 && pending_maps.size() == 0)
         $display("rotation_bilinear_source_mapper test passed");
      else
         $display("rotation_bilinear_source_mapper test failed");
      $finish;
   end

endmodule

FILE: rotation_bilinear_source_mapper.f
+incdir+rtl/core
rtl/core/rbsm_pkg.sv
rtl/core/rbsm_channels.sv
rtl/core/rbsm_front.sv
rtl/core/rbsm_queue.sv
rtl/core/rbsm_back.sv
rtl/core/rotation_bilinear_source_mapper.sv
rtl/core/rbsm_checker.sv
tb/sv/tb.sv
